// File: rtl/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared widths, register indexes, region codes and the config bundle of the
// trapezoid velocity profile core.
// ----------------------------------------------------------------------------
package tvp_pkg;

    // field widths
    localparam int LEN_W      = 20;
    localparam int VEL_W      = 16;
    localparam int ACC_W      = 18;
    localparam int DIST_W     = 21;
    localparam int REGION_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // internal widths
    localparam int SUM_W   = ACC_W + 1;          // acc + dec
    localparam int QUO_W   = 32;                 // saturated quotient / root argument
    localparam int REM_W   = SUM_W + QUO_W;      // divider remainder
    localparam int ROOT_W  = QUO_W / 2;          // root width, one stage per bit
    localparam int PROD_W  = ACC_W + LEN_W + 1;  // 2*rate*distance
    localparam int ARG_W   = PROD_W + 1;         // square + 2*rate*distance

    // distance delay until the cruise values are settled
    localparam int DLY_STAGES = 56;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATH_LENGTH      = 3'd0,
        CFG_MAX_VELOCITY     = 3'd1,
        CFG_MAX_ACCELERATION = 3'd2,
        CFG_MAX_DECELERATION = 3'd3,
        CFG_START_VELOCITY   = 3'd4,
        CFG_END_VELOCITY     = 3'd5
    } t_cfg_idx;

    // profile regions
    typedef enum logic [REGION_W-1:0] {
        REGION_ACCEL  = 2'd0,
        REGION_CRUISE = 2'd1,
        REGION_DECEL  = 2'd2
    } t_region;

    // configuration bundle, rates already forced nonzero
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [VEL_W-1:0] vmax;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] dec;
        logic [VEL_W-1:0] v0;
        logic [VEL_W-1:0] ve;
    } t_cfg;

endpackage

// File: rtl/tvp_sqrt.sv
// ----------------------------------------------------------------------------
// tvp_sqrt
// Pipelined integer square root, one result bit per stage, with a valid bit
// and a side payload that travel alongside.
// ----------------------------------------------------------------------------
module tvp_sqrt
    import tvp_pkg::*;
#(
    parameter int PAY_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [QUO_W-1:0]  i_arg,
    input  logic [PAY_W-1:0]  i_pay,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [PAY_W-1:0]  o_pay
);

    logic [QUO_W-1:0]  r_x   [ROOT_W];
    logic [QUO_W-1:0]  r_r   [ROOT_W];
    logic [PAY_W-1:0]  r_pay [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    genvar gk;
    generate
        for (gk = 0; gk < ROOT_W; gk++) begin : g_stage
            localparam logic [QUO_W-1:0] BIT = QUO_W'(1) << (QUO_W - 2 - 2 * gk);
            logic [QUO_W-1:0] x_in;
            logic [QUO_W-1:0] r_in;
            logic [PAY_W-1:0] pay_in;
            logic             vld_in;
            logic [QUO_W-1:0] n_x;
            logic [QUO_W-1:0] n_r;

            // stage input
            if (gk == 0) begin : g_first
                assign x_in   = i_arg;
                assign r_in   = '0;
                assign pay_in = i_pay;
                assign vld_in = i_vld;
            end else begin : g_next
                assign x_in   = r_x[gk-1];
                assign r_in   = r_r[gk-1];
                assign pay_in = r_pay[gk-1];
                assign vld_in = r_vld[gk-1];
            end

            // one trial subtract
            always_comb begin
                if (x_in >= r_in + BIT) begin
                    n_x = x_in - (r_in + BIT);
                    n_r = (r_in >> 1) + BIT;
                end else begin
                    n_x = x_in;
                    n_r = r_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[gk] <= 1'b0;
                end else begin
                    r_vld[gk] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_x[gk]   <= n_x;
                r_r[gk]   <= n_r;
                r_pay[gk] <= pay_in;
            end
        end
    endgenerate

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_r[ROOT_W-1][ROOT_W-1:0];
    assign o_pay  = r_pay[ROOT_W-1];

endmodule

// File: rtl/tvp_div.sv
// ----------------------------------------------------------------------------
// tvp_div
// Pipelined restoring divider, one quotient bit per stage. The dividend must
// be below divisor times 2^QUO_W; the caller handles the larger case.
// ----------------------------------------------------------------------------
module tvp_div
    import tvp_pkg::*;
(
    input  logic             i_clk,
    input  logic [REM_W-1:0] i_rem,
    input  logic [SUM_W-1:0] i_dvs,
    output logic [QUO_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    genvar gk;
    generate
        for (gk = 0; gk < QUO_W; gk++) begin : g_stage
            logic [REM_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic [REM_W-1:0] dvs_sh;
            logic [REM_W-1:0] n_rem;
            logic [QUO_W-1:0] n_quo;

            if (gk == 0) begin : g_first
                assign rem_in = i_rem;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[gk-1];
                assign quo_in = r_quo[gk-1];
            end

            // divisor aligned to this quotient bit
            assign dvs_sh = REM_W'(i_dvs) << (QUO_W - 1 - gk);

            always_comb begin
                if (rem_in >= dvs_sh) begin
                    n_rem = rem_in - dvs_sh;
                    n_quo = {quo_in[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_in;
                    n_quo = {quo_in[QUO_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[gk] <= n_rem;
                r_quo[gk] <= n_quo;
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_W-1];

endmodule

// File: rtl/tvp_cruise.sv
// ----------------------------------------------------------------------------
// tvp_cruise
// Free-running pipeline that derives the cruise velocity and its square from
// the configuration: ramp-fit test, triangular peak by divide and root.
// ----------------------------------------------------------------------------
module tvp_cruise
    import tvp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    output logic [VEL_W-1:0]    o_cruise,
    output logic [2*VEL_W-1:0]  o_csq
);

    logic [LEN_W+ACC_W-1:0]   r_la;
    logic [2*VEL_W-1:0]       r_vv;
    logic [SUM_W-1:0]         r_sum;
    logic [LEN_W+ACC_W-2:0]   r_plo;
    logic [LEN_W+ACC_W-2:0]   r_phi;
    logic [2*VEL_W+SUM_W-1:0] r_vvs;
    logic [2*VEL_W+SUM_W-1:0] r_vvs_d;
    logic [LEN_W+2*ACC_W:0]   r_lad2;
    logic                     r_fits;
    logic                     r_big;
    logic [REM_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_qsat;
    logic [QUO_W-1:0]         quo;
    logic [ROOT_W-1:0]        root;
    logic                     fits_d;
    logic [VEL_W-1:0]         r_cruise;
    logic [2*VEL_W-1:0]       r_csq;
    logic [LEN_W+2*ACC_W-1:0] lad;

    localparam int HALF_W = (LEN_W + ACC_W) / 2;

    // stage 1: first products and rate sum
    always_ff @(posedge i_clk) begin
        r_la  <= (LEN_W+ACC_W)'(i_cfg.len) * (LEN_W+ACC_W)'(i_cfg.acc);
        r_vv  <= (2*VEL_W)'(i_cfg.vmax) * (2*VEL_W)'(i_cfg.vmax);
        r_sum <= SUM_W'(i_cfg.acc) + SUM_W'(i_cfg.dec);
    end

    // stage 2: L*A*D split into two partial products, V*V*(A+D)
    always_ff @(posedge i_clk) begin
        r_plo <= (LEN_W+ACC_W-1)'(r_la[HALF_W-1:0]) * (LEN_W+ACC_W-1)'(i_cfg.dec);
        r_phi <= (LEN_W+ACC_W-1)'(r_la[LEN_W+ACC_W-1:HALF_W])
                 * (LEN_W+ACC_W-1)'(i_cfg.dec);
        r_vvs <= (2*VEL_W+SUM_W)'(r_vv) * (2*VEL_W+SUM_W)'(r_sum);
    end

    // stage 3: join partial products
    assign lad = {r_phi[LEN_W+2*ACC_W-HALF_W-1:0], HALF_W'(0)}
                 + (LEN_W+2*ACC_W)'(r_plo);

    always_ff @(posedge i_clk) begin
        r_lad2  <= {lad, 1'b0};
        r_vvs_d <= r_vvs;
    end

    // stage 4: ramp-fit test, quotient overflow test
    always_ff @(posedge i_clk) begin
        r_fits <= (LEN_W+2*ACC_W+1)'(r_vvs_d) < r_lad2;
        r_big  <= r_lad2 >= {(LEN_W+2*ACC_W+1-REM_W)'(0), r_sum, QUO_W'(0)};
        r_rem  <= r_lad2[REM_W-1:0];
    end

    tvp_div u_div (
        .i_clk (i_clk),
        .i_rem (r_rem),
        .i_dvs (r_sum),
        .o_quo (quo)
    );

    // saturate the quotient, its root then saturates at full scale
    always_ff @(posedge i_clk) begin
        r_qsat <= r_big ? '1 : quo;
    end

    tvp_sqrt #(
        .PAY_W (1)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (1'b1),
        .i_arg   (r_qsat),
        .i_pay   (r_fits),
        .o_vld   (),
        .o_root  (root),
        .o_pay   (fits_d)
    );

    // cruise select and square
    always_ff @(posedge i_clk) begin
        r_cruise <= fits_d ? i_cfg.vmax : root;
        r_csq    <= (2*VEL_W)'(r_cruise) * (2*VEL_W)'(r_cruise);
    end

    assign o_cruise = r_cruise;
    assign o_csq    = r_csq;

endmodule

// File: rtl/trapezoid_velocity_profile_core.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile_core
// Commanded velocity and region of a trapezoidal profile at a given distance.
// ----------------------------------------------------------------------------
// Usage:
//  - configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one of six registers
//    (length, max velocity, acceleration, deceleration, start and end
//    velocity); indexes beyond five are ignored
//  - input: a distance word is taken at each edge where start is high and
//    busy is low; busy stays low, so a word may enter every cycle
//  - output: o_velocity and o_region are shown for one cycle with o_valid,
//    in input order
//  - throughput: one word per cycle, set by the pipelined root unit (one bit
//    per stage); the cruise pipeline's divider (one bit per stage) works on config
//  - after a register write the derived cruise values settle while a word
//    passes the distance delay line, so a word may follow at once
//  - reset sets the config registers to their defaults and drops every word
//    in flight; there is no other clearing pass
//  - the receiver cannot stall: each result is presented once and not held
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile_core
    import tvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [DIST_W-1:0] i_distance,
    output logic                  o_valid,
    output logic [VEL_W-1:0]      o_velocity,
    output logic [REGION_W-1:0]   o_region
);

    localparam int PIPE_DEPTH = DLY_STAGES + ROOT_W + 5;

    // configuration registers
    logic [LEN_W-1:0] r_len;
    logic [VEL_W-1:0] r_vmax;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_dec;
    logic [VEL_W-1:0] r_v0;
    logic [VEL_W-1:0] r_ve;
    t_cfg             cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(25600);
            r_vmax <= VEL_W'(12800);
            r_acc  <= ACC_W'(25600);
            r_dec  <= ACC_W'(25600);
            r_v0   <= '0;
            r_ve   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PATH_LENGTH:      r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_VELOCITY:     r_vmax <= i_cfg_data[VEL_W-1:0];
                CFG_MAX_ACCELERATION: r_acc  <= i_cfg_data[ACC_W-1:0];
                CFG_MAX_DECELERATION: r_dec  <= i_cfg_data[ACC_W-1:0];
                CFG_START_VELOCITY:   r_v0   <= i_cfg_data[VEL_W-1:0];
                CFG_END_VELOCITY:     r_ve   <= i_cfg_data[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    // zero rate counts as the smallest rate
    always_comb begin
        cfg.len  = r_len;
        cfg.vmax = r_vmax;
        cfg.acc  = (r_acc == '0) ? ACC_W'(1) : r_acc;
        cfg.dec  = (r_dec == '0) ? ACC_W'(1) : r_dec;
        cfg.v0   = r_v0;
        cfg.ve   = r_ve;
    end

    // pipeline takes a word every cycle
    assign busy = 1'b0;

    // cruise velocity from configuration
    logic [VEL_W-1:0]   cruise;
    logic [2*VEL_W-1:0] csq;

    tvp_cruise u_cruise (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .o_cruise (cruise),
        .o_csq    (csq)
    );

    // squares of end velocities and region thresholds
    logic [2*VEL_W-1:0] r_v0sq;
    logic [2*VEL_W-1:0] r_vesq;
    logic               r_a_ok;
    logic [2*VEL_W-1:0] r_a_room;
    logic               r_d_le;
    logic               r_d_eq;
    logic [2*VEL_W-1:0] r_d_room;

    always_ff @(posedge i_clk) begin
        r_v0sq   <= (2*VEL_W)'(cfg.v0) * (2*VEL_W)'(cfg.v0);
        r_vesq   <= (2*VEL_W)'(cfg.ve) * (2*VEL_W)'(cfg.ve);
        r_a_ok   <= csq > r_v0sq;
        r_a_room <= csq - r_v0sq;
        r_d_le   <= csq <= r_vesq;
        r_d_eq   <= csq == r_vesq;
        r_d_room <= csq - r_vesq;
    end

    // stage 1: clamp distance, remaining distance
    logic [LEN_W-1:0] n_d;
    logic             in_acc;

    assign in_acc = start && !busy;

    always_comb begin
        if (i_distance[DIST_W-1]) begin
            n_d = '0;
        end else if (i_distance[LEN_W-1:0] > cfg.len) begin
            n_d = cfg.len;
        end else begin
            n_d = i_distance[LEN_W-1:0];
        end
    end

    // delay line while the cruise values settle
    logic [LEN_W-1:0]    r_dl_d    [DLY_STAGES+1];
    logic [LEN_W-1:0]    r_dl_rest [DLY_STAGES+1];
    logic [DLY_STAGES:0] r_dl_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_vld <= '0;
        end else begin
            r_dl_vld <= {r_dl_vld[DLY_STAGES-1:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl_d[0]    <= n_d;
        r_dl_rest[0] <= cfg.len - n_d;
        for (int k = 1; k <= DLY_STAGES; k++) begin
            r_dl_d[k]    <= r_dl_d[k-1];
            r_dl_rest[k] <= r_dl_rest[k-1];
        end
    end

    // products 2*A*d and 2*D*(L-d)
    logic [PROD_W-1:0] r_ad2;
    logic [PROD_W-1:0] r_dr2;
    logic              r_p_vld;
    logic [PROD_W-2:0] ad;
    logic [PROD_W-2:0] dr;

    assign ad = (PROD_W-1)'(cfg.acc) * (PROD_W-1)'(r_dl_d[DLY_STAGES]);
    assign dr = (PROD_W-1)'(cfg.dec) * (PROD_W-1)'(r_dl_rest[DLY_STAGES]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= r_dl_vld[DLY_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ad2 <= {ad, 1'b0};
        r_dr2 <= {dr, 1'b0};
    end

    // region decision and root argument
    t_region          n_region;
    logic             accel;
    logic             keep;
    logic             on_end;
    logic [ARG_W-1:0] n_sum;
    t_region          r_c_region;
    logic [ARG_W-1:0] r_c_sum;
    logic [VEL_W-1:0] r_c_cruise;
    logic             r_c_vld;

    always_comb begin
        accel  = r_a_ok && (r_ad2 < PROD_W'(r_a_room));
        keep   = r_d_le || (r_dr2 > PROD_W'(r_d_room));
        on_end = r_d_le && (r_dr2 == '0) && r_d_eq;
        if (accel) begin
            n_region = REGION_ACCEL;
        end else if (keep && !on_end) begin
            n_region = REGION_CRUISE;
        end else begin
            n_region = REGION_DECEL;
        end
        if (accel) begin
            n_sum = ARG_W'(r_v0sq) + ARG_W'(r_ad2);
        end else begin
            n_sum = ARG_W'(r_vesq) + ARG_W'(r_dr2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_region <= n_region;
        r_c_sum    <= n_sum;
        r_c_cruise <= cruise;
    end

    // saturate argument, root then saturates at full scale
    logic [QUO_W-1:0]          r_g_arg;
    logic [REGION_W+VEL_W-1:0] r_g_pay;
    logic                      r_g_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_arg <= (r_c_sum[ARG_W-1:QUO_W] != '0) ? '1 : r_c_sum[QUO_W-1:0];
        r_g_pay <= {r_c_region, r_c_cruise};
    end

    logic                      s_vld;
    logic [ROOT_W-1:0]         s_root;
    logic [REGION_W+VEL_W-1:0] s_pay;

    tvp_sqrt #(
        .PAY_W (REGION_W + VEL_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_g_vld),
        .i_arg   (r_g_arg),
        .i_pay   (r_g_pay),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_pay   (s_pay)
    );

    // output word
    logic                r_o_vld;
    logic [VEL_W-1:0]    r_o_vel;
    logic [REGION_W-1:0] r_o_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_region <= s_pay[REGION_W+VEL_W-1:VEL_W];
        if (t_region'(s_pay[REGION_W+VEL_W-1:VEL_W]) == REGION_CRUISE) begin
            r_o_vel <= s_pay[VEL_W-1:0];
        end else begin
            r_o_vel <= VEL_W'(s_root);
        end
    end

    assign o_valid    = r_o_vld;
    assign o_velocity = r_o_vel;
    assign o_region   = r_o_region;

    // checks
    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_region == REGION_ACCEL || o_region == REGION_CRUISE
                     || o_region == REGION_DECEL))
        else $error("result word carries an undefined region code");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word strobed right after reset");

    a_word_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result word without an accepted input word");

endmodule
